### rtl/slbm_pkg.sv
// Shared types and constants for the serial-loaded bank mapper.
`timescale 1ns / 1ps

package slbm_pkg;

  // Bus access kinds
  localparam logic [1:0] ACT_CPU_RD = 2'd0;
  localparam logic [1:0] ACT_CPU_WR = 2'd1;
  localparam logic [1:0] ACT_PPU_RD = 2'd2;
  localparam logic [1:0] ACT_PPU_WR = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;

  localparam logic [4:0] PRG_COUNT_RST = 5'd16;
  localparam logic [4:0] CHR_COUNT_RST = 5'd0;
  localparam logic [4:0] CONTROL_RST   = 5'h1C;

  typedef enum logic [1:0] {
    MIRROR_ONE_LO = 2'd0,
    MIRROR_ONE_HI = 2'd1,
    MIRROR_VERT   = 2'd2,
    MIRROR_HORIZ  = 2'd3
  } mirror_t;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_RAM = 3'd1,
    TGT_PRG_ROM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_CHR_RAM = 3'd4,
    TGT_REG     = 3'd5
  } target_t;

  // Committed bank registers, as seen by the address translation
  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [4:0] prg_sel;
  } bank_state_t;

  // One result beat
  typedef struct packed {
    logic        claimed;
    target_t     target;
    logic [17:0] mem_addr;
    logic        write_enable;
    logic [7:0]  write_data;
    logic [1:0]  mirror_mode;
  } result_t;

endpackage

### rtl/serial_loaded_bank_mapper.sv
// The result of an accepted bus access beat is registered in the result register, or in the skid entry under stall.
// Throughput: one access per cycle while in_ready is high; mapping and loader update finish in the accepting cycle.
// A result register plus one skid entry absorb one beat under stall; in_ready is low
// while the skid entry is full.
// Reset (rst_n low, synchronous): loader cleared, control 0x1C, banks 0, mirror
// horizontal, PRG bank count 16, CHR bank count 0 (CHR RAM), no beats buffered.
`timescale 1ns / 1ps

module serial_loaded_bank_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_bus_addr,
  input  logic [7:0]  in_bus_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_claimed,
  output logic [2:0]  out_target,
  output logic [17:0] out_mem_addr,
  output logic        out_write_enable,
  output logic [7:0]  out_write_data,
  output logic [1:0]  out_mirror_mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic                  accept;
  logic                  reg_wr;
  logic [4:0]            prg_count_r;
  logic [4:0]            chr_count_r;
  logic [1:0]            mirror_nxt;
  slbm_pkg::bank_state_t bank_state;
  slbm_pkg::result_t     res;
  slbm_pkg::result_t     out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r <= slbm_pkg::PRG_COUNT_RST;
      chr_count_r <= slbm_pkg::CHR_COUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == slbm_pkg::CFG_PRG_COUNT) prg_count_r <= cfg_data;
      else if (cfg_index == slbm_pkg::CFG_CHR_COUNT) chr_count_r <= cfg_data;
    end
  end

  assign accept = in_valid && in_ready;
  assign reg_wr = accept && (in_action == slbm_pkg::ACT_CPU_WR) && in_bus_addr[15];

  slbm_serial_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (reg_wr),
    .wr_sel     (in_bus_addr[14:13]),
    .wr_data    (in_bus_data),
    .state      (bank_state),
    .mirror_nxt (mirror_nxt)
  );

  slbm_xlate u_xlate (
    .action    (in_action),
    .bus_addr  (in_bus_addr),
    .bus_data  (in_bus_data),
    .state     (bank_state),
    .prg_count (prg_count_r),
    .chr_count (chr_count_r),
    .mirror    (mirror_nxt),
    .res       (res)
  );

  slbm_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_claimed      = out_data.claimed;
  assign out_target       = out_data.target;
  assign out_mem_addr     = out_data.mem_addr;
  assign out_write_enable = out_data.write_enable;
  assign out_write_data   = out_data.write_data;
  assign out_mirror_mode  = out_data.mirror_mode;

`ifndef SYNTH
  a_unclaimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_claimed |-> out_target == slbm_pkg::TGT_NONE &&
      out_mem_addr == 18'd0 && !out_write_enable)
    else $error("unclaimed beat carries a target or address");

  a_store_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_target == slbm_pkg::TGT_PRG_RAM ||
      out_target == slbm_pkg::TGT_CHR_RAM)
    else $error("store enabled for a read-only target");
`endif

endmodule

### rtl/slbm_serial_regs.sv
// Serial load shift register and committed bank/control registers.
`timescale 1ns / 1ps

module slbm_serial_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [1:0]           wr_sel,
  input  logic [7:0]           wr_data,
  output slbm_pkg::bank_state_t state,
  output logic [1:0]           mirror_nxt
);

  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR_LO  = 2'd1;
  localparam logic [1:0] SEL_CHR_HI  = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;
  localparam logic [2:0] LAST_BIT    = 3'd4;

  logic [4:0] shift_r, shift_nxt;
  logic [2:0] count_r, count_nxt;
  logic [4:0] control_r, control_nxt;
  logic [4:0] chr_lo_r, chr_lo_nxt;
  logic [4:0] chr_hi_r, chr_hi_nxt;
  logic [4:0] prg_r, prg_nxt;
  logic [1:0] mirror_r;
  logic [4:0] shifted;

  assign shifted = {wr_data[0], shift_r[4:1]};

  always_comb begin
    shift_nxt   = shift_r;
    count_nxt   = count_r;
    control_nxt = control_r;
    chr_lo_nxt  = chr_lo_r;
    chr_hi_nxt  = chr_hi_r;
    prg_nxt     = prg_r;
    mirror_nxt  = mirror_r;
    if (wr_en) begin
      if (wr_data[7]) begin
        // bit 7 clears the loader and forces fixed-last-bank PRG mode
        shift_nxt   = '0;
        count_nxt   = '0;
        control_nxt = control_r | 5'h0C;
      end else if (count_r >= LAST_BIT) begin
        shift_nxt = '0;
        count_nxt = '0;
        case (wr_sel)
          SEL_CONTROL: begin
            control_nxt = shifted;
            mirror_nxt  = shifted[1:0];
          end
          SEL_CHR_LO: chr_lo_nxt = shifted;
          SEL_CHR_HI: chr_hi_nxt = shifted;
          SEL_PRG:    prg_nxt    = shifted;
          default:    prg_nxt    = prg_r;
        endcase
      end else begin
        shift_nxt = shifted;
        count_nxt = count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= '0;
      count_r   <= '0;
      control_r <= slbm_pkg::CONTROL_RST;
      chr_lo_r  <= '0;
      chr_hi_r  <= '0;
      prg_r     <= '0;
      mirror_r  <= slbm_pkg::MIRROR_HORIZ;
    end else begin
      shift_r   <= shift_nxt;
      count_r   <= count_nxt;
      control_r <= control_nxt;
      chr_lo_r  <= chr_lo_nxt;
      chr_hi_r  <= chr_hi_nxt;
      prg_r     <= prg_nxt;
      mirror_r  <= mirror_nxt;
    end
  end

  assign state.control = control_r;
  assign state.chr_lo  = chr_lo_r;
  assign state.chr_hi  = chr_hi_r;
  assign state.prg_sel = prg_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_BIT)
    else $error("serial load count out of range");

  a_bit7_reset: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && wr_data[7] |=> count_r == 3'd0 && control_r[3:2] == 2'b11)
    else $error("bit 7 write did not reset the loader");

  a_fifth_commit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !wr_data[7] && count_r == LAST_BIT |=> count_r == 3'd0 && shift_r == 5'd0)
    else $error("fifth bit did not clear the loader");
`endif

endmodule

### rtl/slbm_xlate.sv
// Access decode and PRG/CHR bank address translation.
`timescale 1ns / 1ps

module slbm_xlate (
  input  logic [1:0]            action,
  input  logic [15:0]           bus_addr,
  input  logic [7:0]            bus_data,
  input  slbm_pkg::bank_state_t state,
  input  logic [4:0]            prg_count,
  input  logic [4:0]            chr_count,
  input  logic [1:0]            mirror,
  output slbm_pkg::result_t     res
);

  logic [4:0]  prg_n;
  logic [3:0]  prg_mask;
  logic [3:0]  prg_page;
  logic [17:0] prg_addr;
  logic [4:0]  chr_n;
  logic [4:0]  chr_mask;
  logic [4:0]  chr_page;
  logic [17:0] chr_addr;
  logic        is_cpu;

  // bank counts: PRG zero counts as one, both clamp at sixteen
  assign prg_n    = (prg_count == 5'd0) ? 5'd1 : ((prg_count > 5'd16) ? 5'd16 : prg_count);
  assign prg_mask = 4'(prg_n - 5'd1);
  assign chr_n    = (chr_count > 5'd16) ? 5'd16 : chr_count;
  // sixteen banks wrap to an all-ones mask
  assign chr_mask = {chr_n[3:0], 1'b0} - 5'd1;

  always_comb begin
    case (state.control[3:2])
      2'd0, 2'd1: prg_page = {state.prg_sel[3:1], bus_addr[14]};
      2'd2:       prg_page = bus_addr[14] ? state.prg_sel[3:0] : 4'd0;
      2'd3:       prg_page = bus_addr[14] ? prg_mask : state.prg_sel[3:0];
      default:    prg_page = 4'd0;
    endcase
  end

  assign prg_addr = {prg_page & prg_mask, bus_addr[13:0]};

  always_comb begin
    if (!state.control[4]) chr_page = {state.chr_lo[4:1], bus_addr[12]};
    else chr_page = bus_addr[12] ? state.chr_hi : state.chr_lo;
  end

  assign chr_addr = {1'b0, chr_page & chr_mask, bus_addr[11:0]};
  assign is_cpu   = (action == slbm_pkg::ACT_CPU_RD) || (action == slbm_pkg::ACT_CPU_WR);

  always_comb begin
    res              = '0;
    res.target       = slbm_pkg::TGT_NONE;
    res.mirror_mode  = mirror;
    if (is_cpu) begin
      if (bus_addr[15:13] == 3'b011) begin
        res.claimed      = 1'b1;
        res.target       = slbm_pkg::TGT_PRG_RAM;
        res.mem_addr     = {5'd0, bus_addr[12:0]};
        res.write_enable = (action == slbm_pkg::ACT_CPU_WR);
      end else if (bus_addr[15]) begin
        res.claimed = 1'b1;
        if (action == slbm_pkg::ACT_CPU_RD) begin
          res.target   = slbm_pkg::TGT_PRG_ROM;
          res.mem_addr = prg_addr;
        end else begin
          res.target = slbm_pkg::TGT_REG;
        end
      end
    end else if (bus_addr[15:13] == 3'b000) begin
      if (chr_n == 5'd0) begin
        res.claimed      = 1'b1;
        res.target       = slbm_pkg::TGT_CHR_RAM;
        res.mem_addr     = {5'd0, bus_addr[12:0]};
        res.write_enable = (action == slbm_pkg::ACT_PPU_WR);
      end else if (action == slbm_pkg::ACT_PPU_RD) begin
        res.claimed  = 1'b1;
        res.target   = slbm_pkg::TGT_CHR_ROM;
        res.mem_addr = chr_addr;
      end
    end
    res.write_data = res.write_enable ? bus_data : 8'd0;
  end

endmodule

### rtl/slbm_out_buf.sv
// Result register with a skid stage so input can be taken while output stalls.
`timescale 1ns / 1ps

module slbm_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slbm_pkg::result_t  push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output slbm_pkg::result_t  out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  slbm_pkg::result_t out_r, out_nxt;
  slbm_pkg::result_t skid_r, skid_nxt;
  logic              pop;

  assign pop      = out_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ready |=> skid_valid_r && out_valid_r)
    else $error("buffered beat lost under stall");
`endif

endmodule

### bench/serial_loaded_bank_mapper_tb.sv
// Self-checking bench for the serial-loaded bank mapper: bus accesses, serial loads, bank configs.
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_tb;

  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ACCESSES = 50;
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = slbm_pkg::ACT_CPU_RD;
  logic [15:0] in_bus_addr = '0;
  logic [7:0]  in_bus_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_claimed;
  logic [2:0]  out_target;
  logic [17:0] out_mem_addr;
  logic        out_write_enable;
  logic [7:0]  out_write_data;
  logic [1:0]  out_mirror_mode;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = slbm_pkg::CFG_PRG_COUNT;
  logic [4:0]  cfg_data = '0;

  serial_loaded_bank_mapper dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Mirror of the mapper state
  logic [4:0] prg_count_q, chr_count_q;
  logic [4:0] shift_q;
  logic [2:0] shift_cnt_q;
  logic [4:0] ctrl_q, chr_lo_q, chr_hi_q, prg_sel_q;
  slbm_pkg::mirror_t mirror_q;

  bus_access_t       access_q[$];
  slbm_pkg::result_t mapped_q[$];
  int unsigned access_total = 0;
  int unsigned results_done = 0;
  int unsigned fails = 0;

  function automatic slbm_pkg::result_t map_access(input bus_access_t acc);
    slbm_pkg::result_t r;
    int unsigned nprg, nchr, bank, hi;
    logic [4:0]  shifted;
    r = '0;
    r.target = slbm_pkg::TGT_NONE;
    if (acc.action == slbm_pkg::ACT_CPU_RD || acc.action == slbm_pkg::ACT_CPU_WR) begin
      if (acc.addr >= 16'h6000 && acc.addr < 16'h8000) begin
        r.claimed = 1'b1;
        r.target = slbm_pkg::TGT_PRG_RAM;
        r.mem_addr = 18'(acc.addr[12:0]);
        r.write_enable = (acc.action == slbm_pkg::ACT_CPU_WR);
      end else if (acc.addr >= 16'h8000) begin
        r.claimed = 1'b1;
        if (acc.action == slbm_pkg::ACT_CPU_RD) begin
          nprg = (prg_count_q == 0) ? 1 : (prg_count_q > 16) ? 16 : prg_count_q;
          hi = acc.addr[14];
          case (ctrl_q[3:2])
            2'd0, 2'd1: bank = (prg_sel_q & 5'h0E) + hi;
            2'd2:       bank = hi ? (prg_sel_q & 5'h0F) : 0;
            default:    bank = hi ? (nprg - 1) : (prg_sel_q & 5'h0F);
          endcase
          bank &= nprg - 1;
          r.target = slbm_pkg::TGT_PRG_ROM;
          r.mem_addr = 18'((bank << 14) | acc.addr[13:0]);
        end else begin
          r.target = slbm_pkg::TGT_REG;
          if (acc.data[7]) begin
            shift_q = '0;
            shift_cnt_q = '0;
            ctrl_q |= 5'h0C;
          end else begin
            shifted = {acc.data[0], shift_q[4:1]};
            shift_q = shifted;
            shift_cnt_q = shift_cnt_q + 3'd1;
            if (shift_cnt_q >= 3'd5) begin
              case (acc.addr[14:13])
                2'd0: begin
                  ctrl_q = shifted;
                  mirror_q = slbm_pkg::mirror_t'(shifted[1:0]);
                end
                2'd1: chr_lo_q = shifted;
                2'd2: chr_hi_q = shifted;
                default: prg_sel_q = shifted;
              endcase
              shift_q = '0;
              shift_cnt_q = '0;
            end
          end
        end
      end
    end else if (acc.addr <= 16'h1FFF) begin
      nchr = (chr_count_q > 16) ? 16 : chr_count_q;
      if (nchr == 0) begin
        r.claimed = 1'b1;
        r.target = slbm_pkg::TGT_CHR_RAM;
        r.mem_addr = 18'(acc.addr[12:0]);
        r.write_enable = (acc.action == slbm_pkg::ACT_PPU_WR);
      end else if (acc.action == slbm_pkg::ACT_PPU_RD) begin
        hi = acc.addr[12];
        if (!ctrl_q[4])
          bank = (chr_lo_q & 5'h1E) + hi;
        else
          bank = hi ? chr_hi_q : chr_lo_q;
        bank &= 2 * nchr - 1;
        r.claimed = 1'b1;
        r.target = slbm_pkg::TGT_CHR_ROM;
        r.mem_addr = 18'((bank << 12) | acc.addr[11:0]);
      end
    end
    r.write_data = r.write_enable ? acc.data : 8'h00;
    r.mirror_mode = mirror_q;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  bus_access_t next_acc;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        mapped_q.push_back(map_access('{in_action, in_bus_addr, in_bus_data}));
      if (in_valid && !in_ready) begin
        // hold the beat
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        next_acc = access_q.pop_front();
        in_valid <= 1'b1;
        in_action <= next_acc.action;
        in_bus_addr <= next_acc.addr;
        in_bus_data <= next_acc.data;
        if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is redrawn whenever its random pattern length runs out, plus one long hold-off
  int unsigned stall_mode = 0;
  int unsigned pattern_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(16, 80);
      end else begin
        pattern_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && in_valid && access_q.size() >= 10 && results_done >= 120) begin
        // long stall with the sender still busy, so the input side backs up
        hold_done = 1'b1;
        hold_left = 90;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= !out_ready;
        endcase
      end
    end
  end

  // Result checker
  slbm_pkg::result_t want_r;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mapped_q.size() == 0) begin
        $error("result beat with no access outstanding");
        fails++;
      end else begin
        want_r = mapped_q.pop_front();
        results_done++;
        if (out_claimed !== want_r.claimed) begin
          $error("claimed: expected %0d, got %0d", want_r.claimed, out_claimed);
          fails++;
        end
        if (out_target !== want_r.target) begin
          $error("target: expected %0d, got %0d", want_r.target, out_target);
          fails++;
        end
        if (out_mem_addr !== want_r.mem_addr) begin
          $error("mem_addr: expected 0x%05h, got 0x%05h", want_r.mem_addr, out_mem_addr);
          fails++;
        end
        if (out_write_enable !== want_r.write_enable) begin
          $error("write_enable: expected %0d, got %0d", want_r.write_enable, out_write_enable);
          fails++;
        end
        if (out_write_data !== want_r.write_data) begin
          $error("write_data: expected 0x%02h, got 0x%02h", want_r.write_data, out_write_data);
          fails++;
        end
        if (out_mirror_mode !== want_r.mirror_mode) begin
          $error("mirror_mode: expected %0d, got %0d", want_r.mirror_mode, out_mirror_mode);
          fails++;
        end
      end
    end
  end

  task automatic add_access(input logic [1:0] act, input logic [15:0] a, input logic [7:0] d);
    access_q.push_back('{act, a, d});
    access_total++;
  endtask

  // Any access except a mapper register write
  task automatic add_random_access();
    logic [15:0] a;
    logic [7:0]  d;
    a = $urandom;
    d = $urandom;
    case ($urandom_range(0, 9))
      0: add_access(slbm_pkg::ACT_CPU_RD, a, d);
      1: add_access(slbm_pkg::ACT_CPU_WR, {3'b011, a[12:0]}, d);
      2: add_access(slbm_pkg::ACT_CPU_RD, {3'b011, a[12:0]}, d);
      3, 4: add_access(slbm_pkg::ACT_CPU_RD, {1'b1, a[14:0]}, d);
      5, 6: add_access(slbm_pkg::ACT_PPU_RD, {3'b000, a[12:0]}, d);
      7: add_access(slbm_pkg::ACT_PPU_WR, {3'b000, a[12:0]}, d);
      8: add_access($urandom_range(0, 1) ? slbm_pkg::ACT_PPU_RD : slbm_pkg::ACT_PPU_WR, a, d);
      default: add_access(slbm_pkg::ACT_CPU_WR, 16'($urandom_range(0, 16'h5FFF)), d);
    endcase
  endtask

  // Five register writes, LSB first; the last address picks the register
  task automatic add_serial_load(input logic [1:0] sel, input logic [4:0] value, input bit mix);
    logic [15:0] a;
    for (int i = 0; i < 5; i++) begin
      if (mix && $urandom_range(0, 3) == 0)
        add_random_access();
      a = $urandom;
      if (i == 4)
        a[14:13] = sel;
      add_access(slbm_pkg::ACT_CPU_WR, {1'b1, a[14:0]}, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == slbm_pkg::CFG_PRG_COUNT)
      prg_count_q = val;
    else if (idx == slbm_pkg::CFG_CHR_COUNT)
      chr_count_q = val;
  endtask

  task automatic drain();
    wait (results_done == access_total);
    repeat (4) @(posedge clk);
  endtask

  int unsigned prg_setting[PHASES] = '{16, 8, 1, 2, 0, 31, 3, 16};
  int unsigned chr_setting[PHASES] = '{0, 8, 16, 1, 31, 0, 5, 16};
  int unsigned phase_start;
  int unsigned k;

  initial begin
    prg_count_q = slbm_pkg::PRG_COUNT_RST;
    chr_count_q = slbm_pkg::CHR_COUNT_RST;
    shift_q = '0;
    shift_cnt_q = '0;
    ctrl_q = slbm_pkg::CONTROL_RST;
    chr_lo_q = '0;
    chr_hi_q = '0;
    prg_sel_q = '0;
    mirror_q = slbm_pkg::MIRROR_HORIZ;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // unused indexes must leave the bank counts alone
    write_cfg(CFG_SPARE_2, 5'h1F);
    write_cfg(CFG_SPARE_3, 5'h15);

    for (int p = 0; p < PHASES; p++) begin
      write_cfg(slbm_pkg::CFG_PRG_COUNT, 5'(prg_setting[p]));
      write_cfg(slbm_pkg::CFG_CHR_COUNT, 5'(chr_setting[p]));
      if (p == 0) begin
        add_access(slbm_pkg::ACT_CPU_RD, 16'h0000, 8'h00);
        add_access(slbm_pkg::ACT_CPU_RD, 16'h5FFF, 8'hFF);
        add_access(slbm_pkg::ACT_CPU_WR, 16'h6000, 8'hFF);
        add_access(slbm_pkg::ACT_CPU_RD, 16'h7FFF, 8'h00);
        add_access(slbm_pkg::ACT_CPU_RD, 16'h8000, 8'h00);
        add_access(slbm_pkg::ACT_CPU_RD, 16'hFFFF, 8'h00);
        add_access(slbm_pkg::ACT_PPU_RD, 16'h0000, 8'h00);
        add_access(slbm_pkg::ACT_PPU_WR, 16'h1FFF, 8'hA5);
        add_access(slbm_pkg::ACT_PPU_RD, 16'h2000, 8'h00);
        add_access(slbm_pkg::ACT_PPU_WR, 16'hFFFF, 8'h5A);
        add_access(slbm_pkg::ACT_CPU_WR, 16'h8000, 8'h80);
        add_serial_load(2'd0, 5'h12, 1'b0);
        // partial load cut short by a bit-7 write
        add_access(slbm_pkg::ACT_CPU_WR, 16'hA000, 8'h01);
        add_access(slbm_pkg::ACT_CPU_WR, 16'hFFFF, 8'hFF);
        add_access(slbm_pkg::ACT_CPU_RD, 16'hC000, 8'h00);
        add_access(slbm_pkg::ACT_CPU_WR, 16'h5FFF, 8'h33);
      end
      phase_start = access_total;
      while (access_total - phase_start < PHASE_ACCESSES) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5:
            add_serial_load(2'($urandom), 5'($urandom), $urandom_range(0, 1));
          6: begin
            k = $urandom_range(1, 4);
            repeat (k)
              add_access(slbm_pkg::ACT_CPU_WR, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
            add_access(slbm_pkg::ACT_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
          end
          7:
            add_access(slbm_pkg::ACT_CPU_WR, {1'b1, 15'($urandom)}, 8'($urandom));
          default:
            add_random_access();
        endcase
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/slbm_pkg.sv
rtl/slbm_serial_regs.sv
rtl/slbm_xlate.sv
rtl/slbm_out_buf.sv
rtl/serial_loaded_bank_mapper.sv
bench/serial_loaded_bank_mapper_tb.sv
